### rtl/psa_pkg.sv
// Shared constants, command and status codes, and entry types of the palette slot allocator.
package psa_pkg;

   // store sizes
   localparam int BACK_SLOTS  = 64;
   localparam int VIDEO_SLOTS = 16;
   localparam int BIDX_W      = $clog2(BACK_SLOTS);
   localparam int VIDX_W      = $clog2(VIDEO_SLOTS);
   localparam int CLR_SLOTS   = (BACK_SLOTS > VIDEO_SLOTS) ? BACK_SLOTS : VIDEO_SLOTS;
   localparam int CLR_W       = $clog2(CLR_SLOTS);
   localparam int CNT_W       = CLR_W;

   // field widths of the stream words
   localparam int CMD_W    = 3;
   localparam int PID_W    = 6;
   localparam int STAT_W   = 2;
   localparam int VSLOT_W  = 4;
   localparam int BANK_W   = 8;
   localparam int RC_W     = 8;
   localparam int REQ_BITS = CMD_W + PID_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = STAT_W + PID_W + VSLOT_W + 1 + PID_W + BANK_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [RC_W-1:0] RC_MAX      = '1;
   localparam logic [RC_W-1:0] RC_RESERVED = RC_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC_BACK = 3'd0,
      CMD_FREE_BACK  = 3'd1,
      CMD_USE        = 3'd2,
      CMD_UNUSE      = 3'd3,
      CMD_FREE_VIDEO = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NO_VIDEO = 2'd2
   } stat_type;

   // one backing palette: used flag and the video slot it is mapped to
   typedef struct packed {
      logic              used;
      logic [VIDX_W-1:0] video;
   } back_entry_type;

   // one video slot: reference count and the palette that owns it
   typedef struct packed {
      logic [RC_W-1:0]   refcount;
      logic [BIDX_W-1:0] owner;
   } video_entry_type;

   // request word as seen by the core
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [PID_W-1:0] palette_id;
   } req_fields_type;

   // result fields produced by the core (bank is added at the top)
   typedef struct packed {
      stat_type           status;
      logic [PID_W-1:0]   back_slot;
      logic [VSLOT_W-1:0] video_slot;
      logic               copy_needed;
      logic [PID_W-1:0]   copy_src;
   } rsp_fields_type;

   // core handshake status toward the top level
   typedef struct packed {
      logic ready;
      logic done;
   } core_stat_type;

endpackage

### rtl/psa_core.sv
// Command sequencer of the palette slot allocator with the backing and video slot memories.
module psa_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_go,
   input  psa_pkg::req_fields_type  req_word,
   input  logic                     out_free,
   output psa_pkg::core_stat_type   stat,
   output psa_pkg::rsp_fields_type  res
);
   import psa_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BACK_RD,
      ST_ALLOC,
      ST_VID_RD,
      ST_VSRCH,
      ST_OWNER_RD,
      ST_DONE
   } state_type;

   // memories: backing palettes and video slots
   back_entry_type  back_mem [BACK_SLOTS];
   video_entry_type video_mem [VIDEO_SLOTS];

   back_entry_type  back_rd_ff;
   video_entry_type video_rd_ff;

   logic              back_we;
   logic [BIDX_W-1:0] back_waddr;
   logic [BIDX_W-1:0] back_raddr;
   back_entry_type    back_wdata;
   logic              video_we;
   logic [VIDX_W-1:0] video_waddr;
   logic [VIDX_W-1:0] video_raddr;
   video_entry_type   video_wdata;

   // control and payload registers
   state_type         state_ff,  state_in;
   logic [CLR_W-1:0]  clr_ff,    clr_in;
   cmd_type           cmd_ff,    cmd_in;
   logic [BIDX_W-1:0] pid_ff,    pid_in;
   logic              used_ff,   used_in;
   logic [VIDX_W-1:0] slot_ff,   slot_in;
   logic [BIDX_W-1:0] owner_ff,  owner_in;
   logic [BIDX_W-1:0] baddr_ff,  baddr_in;
   logic [VIDX_W-1:0] vaddr_ff,  vaddr_in;
   logic [CNT_W-1:0]  cnt_ff,    cnt_in;
   logic [BIDX_W-1:0] brover_ff, brover_in;
   logic [VIDX_W-1:0] vrover_ff, vrover_in;
   rsp_fields_type    res_ff,    res_in;

   logic [BIDX_W-1:0] bnext;
   logic [VIDX_W-1:0] vnext;
   logic              req_in_range;

   // round-robin successors; video slot 0 is skipped
   assign bnext = (32'(baddr_ff) == BACK_SLOTS - 1) ? '0 : baddr_ff + 1'b1;
   assign vnext = (32'(vaddr_ff) == VIDEO_SLOTS - 1) ? VIDX_W'(1) : vaddr_ff + 1'b1;
   assign req_in_range = 32'(req_word.palette_id) < BACK_SLOTS;

   // next-state and memory port logic
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cmd_in    = cmd_ff;
      pid_in    = pid_ff;
      used_in   = used_ff;
      slot_in   = slot_ff;
      owner_in  = owner_ff;
      baddr_in  = baddr_ff;
      vaddr_in  = vaddr_ff;
      cnt_in    = cnt_ff;
      brover_in = brover_ff;
      vrover_in = vrover_ff;
      res_in    = res_ff;

      back_we     = 1'b0;
      back_waddr  = pid_ff;
      back_raddr  = pid_ff;
      back_wdata  = '0;
      video_we    = 1'b0;
      video_waddr = slot_ff;
      video_raddr = slot_ff;
      video_wdata = '0;

      stat.ready = (state_ff == ST_IDLE);
      stat.done  = 1'b0;

      case (state_ff)
         // sweep both memories to their reset contents
         ST_CLEAR: begin
            back_we     = 32'(clr_ff) < BACK_SLOTS;
            back_waddr  = BIDX_W'(clr_ff);
            video_we    = 32'(clr_ff) < VIDEO_SLOTS;
            video_waddr = VIDX_W'(clr_ff);
            video_wdata.refcount = (clr_ff == '0) ? RC_RESERVED : '0;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == CLR_SLOTS - 1) begin
               state_in = ST_IDLE;
            end
         end

         // take a command and issue its first read; ignored commands go straight to done
         ST_IDLE: begin
            if (req_go) begin
               cmd_in = cmd_type'(req_word.cmd);
               pid_in = BIDX_W'(req_word.palette_id);
               res_in = '0;
               if (req_word.cmd == CMD_ALLOC_BACK) begin
                  back_raddr = brover_ff;
                  baddr_in   = brover_ff;
                  cnt_in     = '0;
                  state_in   = ST_ALLOC;
               end else if (req_in_range && (req_word.cmd == CMD_FREE_BACK ||
                            req_word.cmd == CMD_USE || req_word.cmd == CMD_UNUSE ||
                            req_word.cmd == CMD_FREE_VIDEO)) begin
                  back_raddr = BIDX_W'(req_word.palette_id);
                  state_in   = ST_BACK_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // scan used flags from the rover, one entry a cycle
         ST_ALLOC: begin
            if (!back_rd_ff.used) begin
               back_we         = 1'b1;
               back_waddr      = baddr_ff;
               back_wdata.used = 1'b1;
               back_wdata.video = back_rd_ff.video;
               brover_in       = baddr_ff;
               res_in.back_slot = PID_W'(baddr_ff);
               res_in.status   = STAT_OK;
               state_in        = ST_DONE;
            end else if (32'(cnt_ff) == BACK_SLOTS - 1) begin
               res_in.status = STAT_FULL;
               state_in      = ST_DONE;
            end else begin
               back_raddr = bnext;
               baddr_in   = bnext;
               cnt_in     = cnt_ff + 1'b1;
            end
         end

         // palette entry is here
         ST_BACK_RD: begin
            used_in = back_rd_ff.used;
            slot_in = back_rd_ff.video;
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_FREE_BACK, CMD_FREE_VIDEO: begin
                  back_we = 1'b1;
                  back_wdata.used  = (cmd_ff == CMD_FREE_VIDEO) ? back_rd_ff.used : 1'b0;
                  back_wdata.video = '0;
                  if (back_rd_ff.video != '0) begin
                     video_raddr = back_rd_ff.video;
                     state_in    = ST_VID_RD;
                  end
               end
               CMD_UNUSE: begin
                  if (back_rd_ff.video != '0) begin
                     video_raddr = back_rd_ff.video;
                     state_in    = ST_VID_RD;
                  end
               end
               CMD_USE: begin
                  if (back_rd_ff.video != '0) begin
                     video_raddr = back_rd_ff.video;
                     state_in    = ST_VID_RD;
                  end else begin
                     video_raddr = vrover_ff;
                     vaddr_in    = vrover_ff;
                     cnt_in      = '0;
                     state_in    = ST_VSRCH;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         // read-modify-write of the mapped slot's count
         ST_VID_RD: begin
            video_we    = 1'b1;
            video_wdata = video_rd_ff;
            case (cmd_ff)
               CMD_USE: begin
                  if (video_rd_ff.refcount != RC_MAX) begin
                     video_wdata.refcount = video_rd_ff.refcount + 1'b1;
                  end
                  res_in.video_slot = VSLOT_W'(slot_ff);
               end
               CMD_UNUSE: begin
                  if (video_rd_ff.refcount != '0) begin
                     video_wdata.refcount = video_rd_ff.refcount - 1'b1;
                  end
               end
               default: begin
                  video_wdata.refcount = '0;
               end
            endcase
            state_in = ST_DONE;
         end

         // look for a slot with zero count, one slot a cycle
         ST_VSRCH: begin
            if (video_rd_ff.refcount == '0) begin
               owner_in   = video_rd_ff.owner;
               slot_in    = vaddr_ff;
               vrover_in  = vaddr_ff;
               back_raddr = video_rd_ff.owner;
               state_in   = ST_OWNER_RD;
            end else if (32'(cnt_ff) == VIDEO_SLOTS - 2) begin
               res_in.status = STAT_NO_VIDEO;
               state_in      = ST_DONE;
            end else begin
               video_raddr = vnext;
               vaddr_in    = vnext;
               cnt_in      = cnt_ff + 1'b1;
            end
         end

         // drop the previous owner if it still points here, then map the new palette
         ST_OWNER_RD: begin
            if (back_rd_ff.video == slot_ff) begin
               back_we          = 1'b1;
               back_waddr       = owner_ff;
               back_wdata.used  = back_rd_ff.used;
               back_wdata.video = '0;
            end
            video_we             = 1'b1;
            video_wdata.refcount = RC_W'(1);
            video_wdata.owner    = pid_ff;
            state_in             = ST_DONE;
         end

         // write the new mapping and hand the result over
         ST_DONE: begin
            if (cmd_ff == CMD_USE && res_ff.status == STAT_OK && res_ff.video_slot == '0) begin
               back_we          = 1'b1;
               back_wdata.used  = used_ff;
               back_wdata.video = slot_ff;
               res_in.video_slot  = VSLOT_W'(slot_ff);
               res_in.copy_needed = 1'b1;
               res_in.copy_src    = PID_W'(pid_ff);
            end else if (out_free) begin
               stat.done = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   // memory ports, registered read
   always_ff @(posedge clock) begin
      if (back_we) begin
         back_mem[back_waddr] <= back_wdata;
      end
      back_rd_ff <= back_mem[back_raddr];
   end

   always_ff @(posedge clock) begin
      if (video_we) begin
         video_mem[video_waddr] <= video_wdata;
      end
      video_rd_ff <= video_mem[video_raddr];
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      pid_ff   <= pid_in;
      used_ff  <= used_in;
      slot_ff  <= slot_in;
      owner_ff <= owner_in;
      baddr_ff <= baddr_in;
      vaddr_ff <= vaddr_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         brover_ff <= '0;
         vrover_ff <= VIDX_W'(1);
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         brover_ff <= brover_in;
         vrover_ff <= vrover_in;
      end
   end

endmodule

### rtl/palette_slot_allocator.sv
// Top level of the palette slot allocator: stream ports, bank register and result register.
//
// Usage: each request word on req_ carries a command and a backing palette index;
// every accepted word yields exactly one result word on rsp_. The csr_ channel
// writes the backing bank, reported as copy_bank with each copy request; write it
// only while no request is in flight.
// Path from acceptance to rsp_tvalid: ignored commands and out-of-range palettes go
// straight to the done state; free and unuse read the palette entry and, for a mapped
// one, then update its video slot; use of a mapped palette does the same; alloc_back
// scans the used flags (the flag scan reads one backing entry a cycle from the memory's
// single read port), and use of an unmapped palette scans for a free video slot (one
// video slot a cycle) and then reads the old owner. One request is worked at a time;
// the next can be accepted in the cycle after the result is loaded.
// Reset: a clearing pass sweeps both memories; req_tready stays low until it ends.
// The csr_ channel is always ready.
// Stall: a result waits in the output register while rsp_tready is low; a finished
// request then holds in the core until the register frees up.
module palette_slot_allocator (
   input  logic                        clock,
   input  logic                        reset,
   // request: [2:0] cmd, [8:3] palette_id
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [psa_pkg::REQ_W-1:0]   req_tdata,
   // result: [1:0] status, [7:2] back_slot, [11:8] video_slot, [12] copy_needed,
   // [18:13] copy_src, [26:19] copy_bank
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [psa_pkg::RSP_W-1:0]   rsp_tdata,
   // backing bank register
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [psa_pkg::BANK_W-1:0]  csr_wdata
);
   import psa_pkg::*;

   core_stat_type     stat;
   rsp_fields_type    res;
   req_fields_type    req_word;
   logic              req_go;
   logic              out_free;

   logic [BANK_W-1:0] bank_ff,       bank_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]  rsp_tdata_ff,  rsp_tdata_in;
   logic [BANK_W-1:0] copy_bank;

   // request word unpacking
   assign req_word.cmd        = req_tdata[CMD_W-1:0];
   assign req_word.palette_id = req_tdata[CMD_W +: PID_W];
   assign req_tready = stat.ready;
   assign req_go     = req_tvalid & stat.ready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   psa_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_go   (req_go),
      .req_word (req_word),
      .out_free (out_free),
      .stat     (stat),
      .res      (res)
   );

   // bank register and result word
   assign csr_ready = 1'b1;
   assign bank_in   = (csr_valid && csr_ready) ? csr_wdata : bank_ff;
   assign copy_bank = res.copy_needed ? bank_ff : '0;
   assign rsp_tdata_in = stat.done ?
      {{(RSP_W - RSP_BITS){1'b0}}, copy_bank, res.copy_src, res.copy_needed,
       res.video_slot, res.back_slot, res.status} : rsp_tdata_ff;
   assign rsp_tvalid_in = stat.done || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      if (reset) begin
         bank_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         bank_ff       <= bank_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   // the core never finishes into an occupied output register
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> out_free)
      else $error("result finished while output register busy");

   // one request at a time
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   // a copy request always names a real video slot
   a_copy_slot: assert property (@(posedge clock) disable iff (reset)
      stat.done && res.copy_needed |-> res.status == STAT_OK && res.video_slot != '0)
      else $error("copy request without a mapped video slot");

   // a finished result is loaded in the next cycle
   a_load: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> rsp_tvalid)
      else $error("finished result not presented");
`endif

endmodule
